// ----- sv/assert_macros.svh -----
// assertion macros shared by the structure factor engine modules
// no dependencies; taken in by include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ESF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ESF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/esf_pkg.sv -----
// types, codes and arithmetic helpers of the structure factor engine
// no dependencies; used by every module of the block
package esf_pkg;

  localparam int unsigned MAX_G_DEF    = 4096;
  localparam int unsigned CFG_W        = 13;
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [3:0] OP_LOAD       = 4'd0;
  localparam logic [3:0] OP_CLEAR      = 4'd1;
  localparam logic [3:0] OP_COPY       = 4'd2;
  localparam logic [3:0] OP_ADD        = 4'd3;
  localparam logic [3:0] OP_E_TRIAL    = 4'd4;
  localparam logic [3:0] OP_E_COMMIT   = 4'd5;
  localparam logic [3:0] OP_CM_COPY    = 4'd6;
  localparam logic [3:0] OP_CM_ADD     = 4'd7;
  localparam logic [3:0] OP_CM_SUB     = 4'd8;

  localparam logic [2:0] K_NOP    = 3'd0;
  localparam logic [2:0] K_LOAD   = 3'd1;
  localparam logic [2:0] K_CLEAR  = 3'd2;
  localparam logic [2:0] K_COPY   = 3'd3;
  localparam logic [2:0] K_ADD    = 3'd4;
  localparam logic [2:0] K_ENERGY = 3'd5;
  localparam logic [2:0] K_COMMIT = 3'd6;

  localparam logic [1:0] CM_COPY = 2'd0;
  localparam logic [1:0] CM_ADD  = 2'd1;
  localparam logic [1:0] CM_SUB  = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STS_SAT       = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic               trial;
    logic [1:0]         cmode;
    logic               bad;
    logic [11:0]        index;
    logic signed [31:0] gvec_x;
    logic signed [31:0] gvec_y;
    logic signed [31:0] gvec_z;
    logic [31:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] charge;
    logic               halve;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_stat_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // {overflow, clamped sum}
  function automatic logic [64:0] sat_add64(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
    logic signed [63:0] r;
    logic ovf;
    r = a + b;
    ovf = (a[63] == b[63]) && (r[63] != a[63]);
    if (ovf) begin
      r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {ovf, r};
  endfunction

  function automatic logic [64:0] sat_sub64(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
    logic signed [63:0] r;
    logic ovf;
    r = a - b;
    ovf = (a[63] != b[63]) && (r[63] != a[63]);
    if (ovf) begin
      r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {ovf, r};
  endfunction

endpackage

// ----- sv/esf_if.sv -----
// item channels of the structure factor engine: command in, result out
// no dependencies
interface esf_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic [11:0]        index;
  logic signed [31:0] gvec_x;
  logic signed [31:0] gvec_y;
  logic signed [31:0] gvec_z;
  logic [31:0]        weight;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] charge;
  logic               halve;
  modport source (output valid, op, index, gvec_x, gvec_y, gvec_z, weight,
                  pos_x, pos_y, pos_z, charge, halve, input ready);
  modport sink (input valid, op, index, gvec_x, gvec_y, gvec_z, weight,
                pos_x, pos_y, pos_z, charge, halve, output ready);
endinterface

interface esf_res_if;
  logic        valid;
  logic        ready;
  logic [62:0] energy;
  logic [1:0]  status;
  modport source (output valid, energy, status, input ready);
  modport sink (input valid, energy, status, output ready);
endinterface

// ----- sv/esf_front.sv -----
// front end: accepts command items, decodes them and queues them
// depends on esf_pkg, esf_if and assert_macros.svh
`include "assert_macros.svh"
module esf_front #(
  parameter int unsigned MAX_G = esf_pkg::MAX_G_DEF
) (
  input  logic              clk,
  input  logic              rst,
  esf_cmd_if.sink           cmd,
  input  esf_pkg::bk_stat_t stat,
  output esf_pkg::fq_t      fq
);
  import esf_pkg::*;

  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  cmd_t           qmem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QCW-1:0] cnt;
  cmd_t           nc;
  logic           push;
  logic           pop;

  always_comb begin
    nc = '0;
    nc.index  = cmd.index;
    nc.gvec_x = cmd.gvec_x;
    nc.gvec_y = cmd.gvec_y;
    nc.gvec_z = cmd.gvec_z;
    nc.weight = cmd.weight;
    nc.pos_x  = cmd.pos_x;
    nc.pos_y  = cmd.pos_y;
    nc.pos_z  = cmd.pos_z;
    nc.charge = cmd.charge;
    nc.halve  = cmd.halve;
    nc.kind   = K_NOP;
    unique case (cmd.op)
      OP_LOAD: begin
        nc.kind = K_LOAD;
        nc.bad  = (32'(cmd.index) >= MAX_G);
      end
      OP_CLEAR:    nc.kind = K_CLEAR;
      OP_COPY:     nc.kind = K_COPY;
      OP_ADD:      nc.kind = K_ADD;
      OP_E_TRIAL: begin
        nc.kind  = K_ENERGY;
        nc.trial = 1'b1;
      end
      OP_E_COMMIT: nc.kind = K_ENERGY;
      OP_CM_COPY: begin
        nc.kind  = K_COMMIT;
        nc.cmode = CM_COPY;
      end
      OP_CM_ADD: begin
        nc.kind  = K_COMMIT;
        nc.cmode = CM_ADD;
      end
      OP_CM_SUB: begin
        nc.kind  = K_COMMIT;
        nc.cmode = CM_SUB;
      end
      default:     nc.kind = K_NOP;
    endcase
  end

  assign cmd.ready = (cnt != QCW'(QDEPTH)) && !stat.init_busy;
  assign push      = cmd.valid && cmd.ready;
  assign pop       = stat.pop;
  assign fq.valid  = (cnt != '0);
  assign fq.cmd    = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= nc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QAW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QAW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ESF_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= QCW'(QDEPTH), "queue overfilled")
  `ESF_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, cnt != '0, "pop from empty queue")
  `ESF_ASSERT_IMP(a_init_block, clk, rst, stat.init_busy, !cmd.ready, "item taken during clear")

endmodule

// ----- sv/esf_back.sv -----
// back end: table memories and per-entry sweep with shared multiplier and cordic
// depends on esf_pkg, esf_if and assert_macros.svh
`include "assert_macros.svh"
module esf_back #(
  parameter int unsigned MAX_G = esf_pkg::MAX_G_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [esf_pkg::CFG_W-1:0] num_gvec,
  input  esf_pkg::fq_t              fq,
  output esf_pkg::bk_stat_t         stat,
  esf_res_if.source                 result
);
  import esf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_G);
  localparam int unsigned KW = $clog2(MAX_G + 1);
  localparam int unsigned NW = (KW > CFG_W) ? KW : CFG_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CSET  = 3'd5;
  localparam logic [2:0] S_CORD  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [127:0] tab_mem [MAX_G];
  logic [127:0] com_mem [MAX_G];
  logic [127:0] tri_mem [MAX_G];
  logic [127:0] tab_q, com_q, tri_q;

  logic [2:0]         state;
  logic [KW-1:0]      k, n, k_inc;
  logic [AW-1:0]      k_addr;
  logic               last;
  cmd_t               cur;
  logic               sat;
  logic [63:0]        eacc;
  logic [127:0]       acc, acc_add;
  logic [87:0]        mreg;
  logic signed [63:0] radd;
  logic [3:0]         mstep;
  logic               ph;
  logic [1:0]         qd;
  logic signed [33:0] cx, cy, cz, dx, dy, at, cval, sval;
  logic [4:0]         ci;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod, psh;
  logic [6:0]         sh;
  logic               res_valid;
  logic [62:0]        res_energy;
  logic [1:0]         res_status;
  logic [NW-1:0]      nfull;

  logic [127:0]       sel;
  logic [63:0]        mre, mim;
  logic [31:0]        ang, dang;
  logic [1:0]         qang;
  logic [64:0]        sa_re, sa_im, cm_re, cm_im, esum;
  logic               t_ovf;
  logic [63:0]        tval, ehalf;
  logic [62:0]        efin;
  logic               eclamp;
  logic [1:0]         sts;

  logic               tab_we, com_we, tri_we;
  logic [AW-1:0]      tab_wa;
  logic [127:0]       com_wd, tri_wd;

  assign k_addr = k[AW-1:0];
  assign k_inc  = k + 1'b1;
  assign last   = (k_inc == n);
  assign nfull  = (NW'(num_gvec) > NW'(MAX_G)) ? NW'(MAX_G) : NW'(num_gvec);

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= {fq.cmd.gvec_x, fq.cmd.gvec_y, fq.cmd.gvec_z, fq.cmd.weight};
    end
    tab_q <= tab_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (com_we) begin
      com_mem[k_addr] <= com_wd;
    end
    com_q <= com_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (tri_we) begin
      tri_mem[k_addr] <= tri_wd;
    end
    tri_q <= tri_mem[k_addr];
  end

  // magnitudes of the selected complex sum
  assign sel = cur.trial ? tri_q : com_q;
  assign mre = sel[127] ? 64'd0 - sel[127:64] : sel[127:64];
  assign mim = sel[63] ? 64'd0 - sel[63:0] : sel[63:0];

  always_comb begin
    unique case (qd)
      2'd0: begin cval = cx;       sval = cy;       end
      2'd1: begin cval = -cy;      sval = cx;       end
      2'd2: begin cval = -cx;      sval = -cy;      end
      default: begin cval = cy;    sval = -cx;      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    sh = '0;
    if (cur.kind == K_ADD) begin
      unique case (mstep)
        4'd0: begin
          ma = {tab_q[127], tab_q[127:96]};
          mb = {cur.pos_x[31], cur.pos_x};
        end
        4'd1: begin
          ma = {tab_q[95], tab_q[95:64]};
          mb = {cur.pos_y[31], cur.pos_y};
        end
        4'd2: begin
          ma = {tab_q[63], tab_q[63:32]};
          mb = {cur.pos_z[31], cur.pos_z};
        end
        4'd3: begin
          ma = {cur.charge[31], cur.charge};
          mb = cval[32:0];
        end
        4'd4: begin
          ma = {cur.charge[31], cur.charge};
          mb = sval[32:0];
        end
        default: ;
      endcase
    end else begin
      unique case (mstep)
        4'd0: begin ma = {1'b0, mre[31:0]};  mb = {1'b0, mre[31:0]};  end
        4'd1: begin ma = {1'b0, mre[31:0]};  mb = {1'b0, mre[63:32]}; sh = 7'd33; end
        4'd2: begin ma = {1'b0, mre[63:32]}; mb = {1'b0, mre[63:32]}; sh = 7'd64; end
        4'd3: begin ma = {1'b0, mim[31:0]};  mb = {1'b0, mim[31:0]};  end
        4'd4: begin ma = {1'b0, mim[31:0]};  mb = {1'b0, mim[63:32]}; sh = 7'd33; end
        4'd5: begin ma = {1'b0, mim[63:32]}; mb = {1'b0, mim[63:32]}; sh = 7'd64; end
        4'd6: begin ma = {1'b0, mreg[31:0]}; mb = {1'b0, tab_q[31:0]}; end
        4'd7: begin
          ma = {1'b0, mreg[63:32]};
          mb = {1'b0, tab_q[31:0]};
          sh = 7'd32;
        end
        4'd8: begin
          ma = {9'd0, mreg[87:64]};
          mb = {1'b0, tab_q[31:0]};
          sh = 7'd64;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign acc_add = acc + ({64'd0, prod[63:0]} << sh);
  assign psh     = prod >>> 14;

  assign ang  = acc[43:12];
  assign qang = ang[31:30] + {~ang[29] & 1'b0, ang[29]};
  assign dang = ang - {qang, 30'd0};

  assign dx = cy >>> ci;
  assign dy = cx >>> ci;
  assign at = signed'({4'd0, atan_turn(ci)});

  assign sa_re = sat_add64(tri_q[127:64], radd);
  assign sa_im = sat_add64(tri_q[63:0], psh[63:0]);

  always_comb begin
    cm_re = {1'b0, tri_q[127:64]};
    cm_im = {1'b0, tri_q[63:0]};
    if (cur.cmode == CM_ADD) begin
      cm_re = sat_add64(com_q[127:64], tri_q[127:64]);
      cm_im = sat_add64(com_q[63:0], tri_q[63:0]);
    end else if (cur.cmode == CM_SUB) begin
      cm_re = sat_sub64(com_q[127:64], tri_q[127:64]);
      cm_im = sat_sub64(com_q[63:0], tri_q[63:0]);
    end
  end

  assign t_ovf = |acc_add[127:96];
  assign tval  = t_ovf ? {64{1'b1}} : acc_add[95:32];
  assign esum  = {1'b0, eacc} + {1'b0, tval};

  assign ehalf  = cur.halve ? {1'b0, eacc[63:1]} : eacc;
  assign eclamp = (cur.kind == K_ENERGY) && ehalf[63];
  assign efin   = (cur.kind != K_ENERGY) ? 63'd0 : (eclamp ? {63{1'b1}} : ehalf[62:0]);
  assign sts    = cur.bad ? STS_BAD_INDEX : ((sat || eclamp) ? STS_SAT : STS_OK);

  always_comb begin
    tab_we = 1'b0;
    tab_wa = AW'(fq.cmd.index);
    com_we = 1'b0;
    com_wd = '0;
    tri_we = 1'b0;
    tri_wd = '0;
    unique case (state)
      S_INIT: begin
        com_we = 1'b1;
        tri_we = 1'b1;
      end
      S_IDLE: tab_we = fq.valid && (fq.cmd.kind == K_LOAD) && !fq.cmd.bad;
      S_EXEC: begin
        if (cur.kind == K_CLEAR) begin
          tri_we = 1'b1;
        end else if (cur.kind == K_COPY) begin
          tri_we = 1'b1;
          tri_wd = com_q;
        end else if (cur.kind == K_COMMIT) begin
          com_we = 1'b1;
          com_wd = {cm_re[63:0], cm_im[63:0]};
        end
      end
      S_MUL: begin
        if (ph && (cur.kind == K_ADD) && (mstep == 4'd4)) begin
          tri_we = 1'b1;
          tri_wd = {sa_re[63:0], sa_im[63:0]};
        end
      end
      default: ;
    endcase
  end

  assign stat.pop       = (state == S_IDLE) && fq.valid;
  assign stat.init_busy = (state == S_INIT);

  assign result.valid  = res_valid;
  assign result.energy = res_energy;
  assign result.status = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (k == KW'(MAX_G - 1)) begin
            k     <= '0;
            state <= S_IDLE;
          end else begin
            k <= k_inc;
          end
        end
        S_IDLE: begin
          if (fq.valid) begin
            cur  <= fq.cmd;
            n    <= KW'(nfull);
            k    <= '0;
            sat  <= 1'b0;
            eacc <= '0;
            if ((fq.cmd.kind == K_LOAD) || (fq.cmd.kind == K_NOP) || (nfull == '0)) begin
              state <= S_OUT;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          if ((cur.kind == K_ADD) || (cur.kind == K_ENERGY)) begin
            acc   <= '0;
            mstep <= '0;
            ph    <= 1'b0;
            state <= S_MUL;
          end else begin
            if (cur.kind == K_COMMIT) begin
              sat <= sat | cm_re[64] | cm_im[64];
            end
            k     <= k_inc;
            state <= last ? S_OUT : S_FETCH;
          end
        end
        S_MUL: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph    <= 1'b0;
            acc   <= ((cur.kind != K_ADD) && (mstep == 4'd5)) ? '0 : acc_add;
            mstep <= mstep + 1'b1;
            if (cur.kind == K_ADD) begin
              if (mstep == 4'd2) begin
                state <= S_CSET;
              end else if (mstep == 4'd3) begin
                radd <= psh[63:0];
              end else if (mstep == 4'd4) begin
                sat   <= sat | sa_re[64] | sa_im[64];
                k     <= k_inc;
                state <= last ? S_OUT : S_FETCH;
              end
            end else begin
              if (mstep == 4'd5) begin
                mreg <= acc_add[127:40];
              end else if (mstep == 4'd8) begin
                eacc  <= esum[64] ? {64{1'b1}} : esum[63:0];
                sat   <= sat | t_ovf | esum[64];
                k     <= k_inc;
                state <= last ? S_OUT : S_FETCH;
              end
            end
          end
        end
        S_CSET: begin
          qd    <= qang;
          cz    <= {{2{dang[31]}}, dang};
          cx    <= CORDIC_GAIN;
          cy    <= '0;
          ci    <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + at;
          end
          ci <= ci + 1'b1;
          if (ci == 5'(CORDIC_STEPS - 1)) begin
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_energy <= efin;
            res_status <= sts;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ESF_ASSERT_IMP(a_k_bound, clk, rst, state == S_FETCH || state == S_EXEC, k < n, "entry past count")
  `ESF_ASSERT_IMP(a_no_out_init, clk, rst, state == S_INIT, !res_valid, "result during clear")
  `ESF_ASSERT_IMP(a_cord_len, clk, rst, state == S_CORD, ci < 5'(CORDIC_STEPS), "cordic overrun")

endmodule

// ----- sv/ewald_structure_factor_engine.sv -----
// top level of the reciprocal-space structure factor engine
// depends on esf_pkg, esf_if, esf_front and esf_back
//
// channels: cmd carries one command item (op, index, vector, weight, position,
// charge, halve) with valid/ready; result returns one item (energy, status)
// per command, in order. cfg_we/cfg_wdata write num_gvec; the user writes it only
// while the block idles, the block itself does not enforce this. a two-entry
// command queue sits between the decode front and the sweep back, so commands
// are taken while a result waits for the receiver. each command sweeps entries
// 0..n-1, n = min(num_gvec, MAX_G), one at a time:
//   clear, copy and commit pass through a fetch and an execute state per entry
//   energy takes nine 32x32 partial products per entry
//   add point takes 3 phase products, 24 cordic steps and 2 charge products
//   per entry; load and unused codes go from dispatch straight to the result,
//   and every sweep also passes through dispatch and the result
// the shared multiplier and the table memories set these steps.
// after reset a clearing pass over all MAX_G entries zeroes the sums; no command is
// taken meanwhile. a stalled receiver holds the result register and the
// back end waits at the end of the next command until it is free.
module ewald_structure_factor_engine #(
  parameter int unsigned MAX_G = esf_pkg::MAX_G_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [esf_pkg::CFG_W-1:0] cfg_wdata,
  esf_cmd_if.sink                   cmd,
  esf_res_if.source                 result
);
  import esf_pkg::*;

  logic [CFG_W-1:0] num_gvec;
  fq_t              fq;
  bk_stat_t         stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_gvec <= '0;
    end else if (cfg_we) begin
      num_gvec <= cfg_wdata;
    end
  end

  esf_front #(.MAX_G(MAX_G)) u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .fq   (fq)
  );

  esf_back #(.MAX_G(MAX_G)) u_back (
    .clk      (clk),
    .rst      (rst),
    .num_gvec (num_gvec),
    .fq       (fq),
    .stat     (stat),
    .result   (result)
  );

endmodule

// ----- tb/ewald_structure_factor_engine_tb.sv -----
// self-checking bench for ewald_structure_factor_engine: directed table, then random items
// compared against a fixed-point structure factor predictor kept in this file
// depends on esf_pkg, esf_if and the rtl of the block
module ewald_structure_factor_engine_tb;
  import esf_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int unsigned TBL = 4096;
  localparam int unsigned N_DIR = 22;
  localparam int unsigned N_EMPTY = 4;
  localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam longint ATAN[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic [3:0]         op;
    logic [11:0]        index;
    logic signed [31:0] gx, gy, gz;
    logic [31:0]        weight;
    logic signed [31:0] px, py, pz, charge;
    logic               halve;
  } sf_cmd_t;

  typedef struct {
    sf_cmd_t     c;
    bit          typed;
    logic [62:0] energy;
    logic [1:0]  status;
  } sf_row_t;

  typedef struct {
    logic [62:0] energy;
    logic [1:0]  status;
  } sf_res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  esf_cmd_if cmd_ch();
  esf_res_if res_ch();

  ewald_structure_factor_engine uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch), .result(res_ch)
  );

  logic signed [31:0] vx_tab[TBL], vy_tab[TBL], vz_tab[TBL];
  logic [31:0] w_tab[TBL];
  longint com_re[TBL], com_im[TBL], tri_re[TBL], tri_im[TBL];
  int unsigned num_cfg;

  sf_res_t pending_res[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int src_idle = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", pending_res.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint sadd(longint a, longint b, inout bit sat);
    longint r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat = 1;
      r = a[63] ? SUM_MIN : SUM_MAX;
    end
    return r;
  endfunction

  function automatic longint ssub(longint a, longint b, inout bit sat);
    longint r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      sat = 1;
      r = a[63] ? SUM_MIN : SUM_MAX;
    end
    return r;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] t32, d;
    logic [1:0] q;
    longint x, y, z, dx, dy;
    t32 = ang + 32'h2000_0000;
    q = t32[31:30];
    d = ang - {q, 30'd0};
    z = longint'($signed(d));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [63:0] weighted_mag(longint re, longint im, logic [31:0] w,
                                               inout bit sat);
    logic [63:0] ar, ai;
    logic [127:0] sq;
    logic [87:0] m;
    logic [119:0] t;
    ar = re < 0 ? -re : re;
    ai = im < 0 ? -im : im;
    sq = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
    m = 88'(sq >> 40);
    t = 120'(m) * 120'(w);
    t = t >> 32;
    if (t[119:64] != 0) begin
      sat = 1;
      return '1;
    end
    return t[63:0];
  endfunction

  function automatic sf_res_t apply_cmd(sf_cmd_t c);
    sf_res_t r;
    int unsigned n;
    bit sat;
    longint p, co, si;
    logic [64:0] acc;
    n = num_cfg > TBL ? TBL : num_cfg;
    sat = 0;
    r.energy = '0;
    r.status = STS_OK;
    case (c.op)
      OP_LOAD: begin
        if (c.index >= TBL) r.status = STS_BAD_INDEX;
        else begin
          vx_tab[c.index] = c.gx; vy_tab[c.index] = c.gy;
          vz_tab[c.index] = c.gz; w_tab[c.index] = c.weight;
        end
      end
      OP_CLEAR: for (int k = 0; k < n; k++) begin tri_re[k] = 0; tri_im[k] = 0; end
      OP_COPY: for (int k = 0; k < n; k++) begin
        tri_re[k] = com_re[k]; tri_im[k] = com_im[k];
      end
      OP_ADD: for (int k = 0; k < n; k++) begin
        p = longint'(vx_tab[k]) * longint'(c.px) + longint'(vy_tab[k]) * longint'(c.py)
          + longint'(vz_tab[k]) * longint'(c.pz);
        rotate(p[43:12], co, si);
        tri_re[k] = sadd(tri_re[k], (longint'(c.charge) * co) >>> 14, sat);
        tri_im[k] = sadd(tri_im[k], (longint'(c.charge) * si) >>> 14, sat);
      end
      OP_E_TRIAL, OP_E_COMMIT: begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          if (c.op == OP_E_TRIAL)
            acc = acc + 65'(weighted_mag(tri_re[k], tri_im[k], w_tab[k], sat));
          else acc = acc + 65'(weighted_mag(com_re[k], com_im[k], w_tab[k], sat));
          if (acc[64]) begin
            acc = {1'b0, 64'hffff_ffff_ffff_ffff};
            sat = 1;
          end
        end
        if (c.halve) acc = acc >> 1;
        if (acc[63]) begin
          acc = {2'b00, {63{1'b1}}};
          sat = 1;
        end
        r.energy = acc[62:0];
      end
      OP_CM_COPY: for (int k = 0; k < n; k++) begin
        com_re[k] = tri_re[k]; com_im[k] = tri_im[k];
      end
      OP_CM_ADD: for (int k = 0; k < n; k++) begin
        com_re[k] = sadd(com_re[k], tri_re[k], sat);
        com_im[k] = sadd(com_im[k], tri_im[k], sat);
      end
      OP_CM_SUB: for (int k = 0; k < n; k++) begin
        com_re[k] = ssub(com_re[k], tri_re[k], sat);
        com_im[k] = ssub(com_im[k], tri_im[k], sat);
      end
      default: ;
    endcase
    if (sat && r.status == STS_OK) r.status = STS_SAT;
    return r;
  endfunction

  function automatic sf_cmd_t mk(logic [3:0] op, logic [11:0] idx,
                                 logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                 logic [31:0] w, logic [31:0] px, logic [31:0] py,
                                 logic [31:0] pz, logic [31:0] q, logic h);
    sf_cmd_t c;
    c.op = op; c.index = idx; c.gx = gx; c.gy = gy; c.gz = gz; c.weight = w;
    c.px = px; c.py = py; c.pz = pz; c.charge = q; c.halve = h;
    return c;
  endfunction

  function automatic sf_row_t dir_row(int i);
    sf_row_t r;
    r.typed = 1;
    r.energy = '0;
    r.status = STS_OK;
    case (i)
      // nothing in use yet: every sweep is empty
      0:  r.c = mk(OP_E_TRIAL, 12'hfff, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      1:  r.c = mk(OP_E_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      2:  r.c = mk(OP_CM_ADD, 12'h555, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      3:  r.c = mk(OP_SPARE_HI, 12'haaa, '1, '1, '1, '1, '1, '1, '1, '1, 1);
      // four entries in use
      4:  r.c = mk(OP_LOAD, 0, 32'h7fffffff, 32'h80000000, 0, 32'hffffffff,
                   0, 0, 0, 0, 0);
      5:  r.c = mk(OP_LOAD, 1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0,
                   0, 0, 0, 0, 0);
      6:  r.c = mk(OP_LOAD, 2, 0, 0, 0, 32'h01000000, 0, 0, 0, 0, 0);
      7:  r.c = mk(OP_LOAD, 3, 32'h12345678, 32'hedcba987, 32'h0fedcba9, 32'h00800000,
                   0, 0, 0, 0, 0);
      8:  r.c = mk(OP_LOAD, 12'hfff, 32'h10000000, 0, 0, 32'h01000000, 0, 0, 0, 0, 0);
      9:  begin r.typed = 0; r.c = mk(OP_ADD, 12'h123, 0, 0, 0, 0,
                   32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 0); end
      10: begin r.typed = 0; r.c = mk(OP_ADD, 0, 0, 0, 0, 0,
                   0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0); end
      11: begin r.typed = 0; r.c = mk(OP_ADD, 0, 0, 0, 0, 0,
                   32'h00018000, 32'hffff0000, 32'h00000001, 32'h01000000, 1); end
      12: begin r.typed = 0; r.c = mk(OP_E_TRIAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      13: begin r.typed = 0; r.c = mk(OP_E_TRIAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1); end
      14: begin r.typed = 0; r.c = mk(OP_CM_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      15: begin r.typed = 0; r.c = mk(OP_CM_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      16: begin r.typed = 0; r.c = mk(OP_E_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      17: begin r.typed = 0; r.c = mk(OP_CM_SUB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      18: begin r.typed = 0; r.c = mk(OP_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); end
      19: r.c = mk(OP_CLEAR, 12'hfff, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      20: r.c = mk(OP_E_TRIAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      default: r.c = mk(OP_SPARE_LO, 12'hfff, '1, 0, '1, 0, '1, 0, '1, 0, 1);
    endcase
    return r;
  endfunction

  function automatic sf_cmd_t rand_cmd();
    sf_cmd_t c;
    int pick;
    c = mk(OP_LOAD, 12'($urandom), $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    pick = $urandom_range(99);
    if (pick < 15) c.op = OP_LOAD;
    else if (pick < 42) c.op = OP_ADD;
    else if (pick < 52) c.op = OP_E_TRIAL;
    else if (pick < 62) c.op = OP_E_COMMIT;
    else if (pick < 68) c.op = OP_CLEAR;
    else if (pick < 74) c.op = OP_COPY;
    else if (pick < 80) c.op = OP_CM_COPY;
    else if (pick < 88) c.op = OP_CM_ADD;
    else if (pick < 95) c.op = OP_CM_SUB;
    else c.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return c;
  endfunction

  // expects to start at a falling edge, returns at one
  task automatic send_cmd(sf_cmd_t c, bit typed = 0, sf_res_t want = '{0, 0});
    sf_res_t got;
    while ($urandom_range(99) < src_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.op <= c.op; cmd_ch.index <= c.index;
    cmd_ch.gvec_x <= c.gx; cmd_ch.gvec_y <= c.gy; cmd_ch.gvec_z <= c.gz;
    cmd_ch.weight <= c.weight;
    cmd_ch.pos_x <= c.px; cmd_ch.pos_y <= c.py; cmd_ch.pos_z <= c.pz;
    cmd_ch.charge <= c.charge; cmd_ch.halve <= c.halve;
    do @(posedge clk); while (!cmd_ch.ready);
    got = apply_cmd(c);
    pending_res.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain(int extra = 40);
    cmd_ch.valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_num(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    num_cfg = v;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    sf_res_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.status == STS_SAT) sat_seen++;
      if (pending_res.size() == 0) begin
        flag("unexpected item", 64'd0, 64'(res_ch.energy));
      end else begin
        w = pending_res.pop_front();
        if (res_ch.energy !== w.energy)
          flag("energy", 64'(w.energy), 64'(res_ch.energy));
        if (res_ch.status !== w.status)
          flag("status", 64'(w.status), 64'(res_ch.status));
      end
    end
  end

  initial begin
    sf_row_t row;
    sf_cmd_t c;
    int idle_tab[4] = '{0, 88, 0, 9};
    int stall_tab[4] = '{0, 0, 88, 9};
    for (int k = 0; k < TBL; k++) begin
      vx_tab[k] = 0; vy_tab[k] = 0; vz_tab[k] = 0; w_tab[k] = 0;
      com_re[k] = 0; com_im[k] = 0; tri_re[k] = 0; tri_im[k] = 0;
    end
    num_cfg = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0; cmd_ch.op = '0; cmd_ch.index = '0;
    cmd_ch.gvec_x = '0; cmd_ch.gvec_y = '0; cmd_ch.gvec_z = '0; cmd_ch.weight = '0;
    cmd_ch.pos_x = '0; cmd_ch.pos_y = '0; cmd_ch.pos_z = '0; cmd_ch.charge = '0;
    cmd_ch.halve = 1'b0;
    res_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_num(0);
    for (int i = 0; i < N_DIR; i++) begin
      if (i == N_EMPTY) begin
        drain();
        write_num(4);
      end
      row = dir_row(i);
      send_cmd(row.c, row.typed, '{row.energy, row.status});
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle = idle_tab[ph];
      stall_pct = stall_tab[ph];
      write_num(ph == 0 ? 16 : $urandom_range(1, 16));
      if (ph == 0) begin
        for (int k = 0; k < 16; k++) begin
          c = rand_cmd();
          c.op = OP_LOAD;
          c.index = 12'(k);
          send_cmd(c);
        end
        // build up sums, then double the committed sums until they clamp
        c = rand_cmd(); c.op = OP_ADD; c.charge = 32'h7fffffff; send_cmd(c);
        c.op = OP_CM_COPY; send_cmd(c);
        for (int k = 0; k < 17; k++) begin
          c.op = OP_COPY; send_cmd(c);
          c.op = OP_CM_ADD; send_cmd(c);
          if (k % 4 == 3) begin
            c.op = OP_E_COMMIT; send_cmd(c);
          end
        end
        c.op = OP_CLEAR; send_cmd(c);
        c.op = OP_CM_SUB; send_cmd(c);
        // long receiver hold-off with loads streaming in
        hold_req = 1;
        for (int k = 0; k < 8; k++) begin
          c = rand_cmd();
          c.op = OP_LOAD;
          c.index = 12'($urandom_range(16, TBL - 1));
          send_cmd(c);
        end
        cmd_ch.valid <= 1'b0;
        wait (pending_res.size() == 0);
        @(negedge clk);
      end
      for (int k = 0; k < 11; k++) send_cmd(rand_cmd());
      drain();
    end

    src_idle = 0;
    stall_pct = 0;
    write_num(TBL);
    c = rand_cmd();
    c.op = OP_CLEAR; send_cmd(c);
    c.op = OP_COPY; send_cmd(c);
    c.op = OP_CM_ADD; send_cmd(c);
    drain();
    write_num(8191);
    c.op = OP_CM_SUB; send_cmd(c);
    c.op = OP_CM_COPY; send_cmd(c);
    drain();
    write_num(3);
    c.op = OP_E_COMMIT; send_cmd(c);
    c.op = OP_E_TRIAL; send_cmd(c);
    drain(60);

    $display("%0d items sent, %0d results checked, %0d saturating", items_sent,
             results_seen, sat_seen);
    $display("sizes 0 to 8191 entries, all ops, four idle and stall mixes");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_res.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
